FILE: rtl/core/sdcla_pkg.sv
`timescale 1ns / 1ps
package sdcla_pkg;

  localparam int POS_W   = 12;
  localparam int SCORE_W = 24;
  localparam int IDX_W   = 10;
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] REG_ROW_OPEN   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ROW_EXTEND = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_COL_OPEN   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_COL_EXTEND = 2'd3;

  typedef struct packed {
    logic [POS_W-1:0]          dot_row;
    logic [POS_W-1:0]          dot_col;
    logic signed [SCORE_W-1:0] dot_score;
    logic                      last_dot;
  } dot_in_t;

  typedef struct packed {
    logic [IDX_W-1:0]          dot_index;
    logic signed [SCORE_W-1:0] chain_score;
    logic                      kept;
    logic                      has_pred;
    logic [IDX_W-1:0]          pred_index;
    logic                      best_valid;
    logic [IDX_W-1:0]          best_dot;
    logic [SCORE_W-2:0]        best_score;
    logic                      overflow;
    logic                      last_out;
  } dot_out_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_FINISH,
    ST_OUT
  } state_t;

endpackage

FILE: rtl/core/sparse_dot_chain_local_align.sv
`timescale 1ns / 1ps
// Sparse local chaining of alignment dots.
// A dot request (row, column, score, last flag) enters on the in channel;
// one result request leaves on the out channel for every dot. Gap costs are
// to be written through the configuration channel while the block is idle.
// Each dot reads every stored chain entry once from a single-port memory
// whose read data is registered; the entry then passes a registered gap
// multiply, and the add, saturation and compare into the running best take
// the following cycle. Only one dot is in work at a time. A dot that
// arrives once MAX_DOTS dots of the alignment have been counted, or the
// store is full, is dropped without a scan; its result goes from the scan
// state to the output register and is reported with the overflow flag set.
// The block itself does not enforce the idle rule for gap cost writes.
// The result sits in an output register; while the receiver stalls the
// block holds it and takes no new dot. After the last dot of an alignment
// the store count, dot counter and global best return to zero, so the
// memory needs no clearing pass. Reset clears the gap registers and all
// control state at once; store entries are never used before written.
module sparse_dot_chain_local_align
  import sdcla_pkg::*;
#(
  parameter int MAX_DOTS = 1024
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  dot_in_t              in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output dot_out_t             out_data,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [SCORE_W-1:0]   cfg_data
);

  localparam int ADDR_W = (MAX_DOTS > 1) ? $clog2(MAX_DOTS) : 1;
  localparam int CNT_W  = $clog2(MAX_DOTS + 1);
  localparam int ENT_W  = 2 * POS_W + SCORE_W + IDX_W;
  localparam int PROD_W = SCORE_W + POS_W + 1;
  localparam int WIDE_W = SCORE_W + POS_W + 4;
  localparam logic signed [WIDE_W-1:0] SMAX =
    WIDE_W'((64'sd1 <<< (SCORE_W - 1)) - 1);
  localparam logic signed [WIDE_W-1:0] SMIN = -SMAX - WIDE_W'(1);

  function automatic logic signed [SCORE_W-1:0] sat_s(logic signed [WIDE_W-1:0] x);
    if (x > SMAX) return SMAX[SCORE_W-1:0];
    if (x < SMIN) return SMIN[SCORE_W-1:0];
    return x[SCORE_W-1:0];
  endfunction

  // Configuration registers.
  logic signed [SCORE_W-1:0] row_open, row_ext, col_open, col_ext;
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      row_open <= '0;
      row_ext  <= '0;
      col_open <= '0;
      col_ext  <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_ROW_OPEN:   row_open <= cfg_data;
        REG_ROW_EXTEND: row_ext  <= cfg_data;
        REG_COL_OPEN:   col_open <= cfg_data;
        REG_COL_EXTEND: col_ext  <= cfg_data;
        default: ;
      endcase
    end
  end

  // Store of kept dots: row, column, chain, dot index.
  logic [ENT_W-1:0] mem [MAX_DOTS];
  logic [ENT_W-1:0] rd_data;
  logic [ADDR_W-1:0] rd_addr;
  logic              wr_en;
  logic [ENT_W-1:0]  wr_data;
  logic [ADDR_W-1:0] wr_addr;
  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    rd_data <= mem[rd_addr];
  end

  state_t state, state_next;
  dot_in_t cur;
  logic [CNT_W-1:0] kept_count, dot_counter, scan_cnt;
  logic [IDX_W-1:0] best_end;
  logic [SCORE_W-2:0] best_total;
  logic best_flag;
  logic ovf_now;
  dot_out_t res;

  // Pipe stage valids: read data present, cost computed.
  logic v_rd, v_cost;
  // Cost stage registers.
  logic                      c_ok;
  logic signed [SCORE_W-1:0] c_chain;
  logic [POS_W-1:0]          c_row, c_col;
  logic [IDX_W-1:0]          c_id;
  logic signed [PROD_W-1:0]  c_rprod, c_cprod;
  logic                      c_rgap, c_cgap;
  // Running best candidate.
  logic                      b_has;
  logic signed [SCORE_W-1:0] b_score;
  logic [POS_W-1:0]          b_row, b_col;
  logic [IDX_W-1:0]          b_id;

  logic [POS_W-1:0]          e_row, e_col;
  logic signed [SCORE_W-1:0] e_chain;
  logic [IDX_W-1:0]          e_id;
  assign {e_row, e_col, e_chain, e_id} = rd_data;

  logic [POS_W-1:0] drow, dcol;
  assign drow = cur.dot_row - e_row;
  assign dcol = cur.dot_col - e_col;

  logic signed [SCORE_W-1:0] rterm, cterm, cand;
  logic take;
  always_comb begin
    rterm = c_rgap ? sat_s(WIDE_W'(row_open) + WIDE_W'(c_rprod)) : '0;
    cterm = c_cgap ? sat_s(WIDE_W'(col_open) + WIDE_W'(c_cprod)) : '0;
    cand  = sat_s(WIDE_W'(c_chain) + WIDE_W'(rterm) + WIDE_W'(cterm));
    take  = (cand > b_score) || ((cand == b_score) &&
            (!b_has || c_col > b_col || (c_col == b_col && c_row >= b_row)));
  end

  logic scan_done;
  assign scan_done = (scan_cnt == kept_count);
  assign ovf_now = (dot_counter >= CNT_W'(MAX_DOTS)) || (kept_count >= CNT_W'(MAX_DOTS));
  assign rd_addr = scan_cnt[ADDR_W-1:0];

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:   if (in_valid) state_next = ST_SCAN;
      ST_SCAN:   if (ovf_now || scan_done) state_next = ovf_now ? ST_OUT : ST_DRAIN;
      ST_DRAIN:  if (!v_rd && !v_cost) state_next = ST_FINISH;
      ST_FINISH: state_next = ST_OUT;
      ST_OUT:    if (out_ready) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready  = (state == ST_IDLE);
    out_valid = (state == ST_OUT);
    out_data  = res;
  end

  logic signed [SCORE_W-1:0] chain_f;
  assign chain_f = b_has ? sat_s(WIDE_W'(b_score) + WIDE_W'(cur.dot_score)) : cur.dot_score;
  logic [IDX_W-1:0] me;
  assign me = dot_counter[IDX_W-1:0];
  assign wr_en   = (state == ST_FINISH) && !chain_f[SCORE_W-1];
  assign wr_addr = kept_count[ADDR_W-1:0];
  assign wr_data = {cur.dot_row, cur.dot_col, chain_f, me};

  // Result words for a finished dot and for a dropped dot. A kept chain that
  // beats the global best is reported as the new best right away.
  dot_out_t fin_res, ovf_res;
  logic best_up;
  always_comb begin
    best_up = !chain_f[SCORE_W-1] && (chain_f > $signed({1'b0, best_total}));
    fin_res = '0;
    fin_res.dot_index   = me;
    fin_res.chain_score = chain_f;
    fin_res.kept        = !chain_f[SCORE_W-1];
    fin_res.has_pred    = b_has;
    fin_res.pred_index  = b_has ? b_id : '0;
    fin_res.last_out    = cur.last_dot;
    fin_res.best_valid  = best_flag || best_up;
    fin_res.best_dot    = best_up ? me : (best_flag ? best_end : '0);
    fin_res.best_score  = best_up ? chain_f[SCORE_W-2:0] : (best_flag ? best_total : '0);
    ovf_res = '0;
    ovf_res.overflow    = 1'b1;
    ovf_res.best_valid  = best_flag;
    ovf_res.best_dot    = best_flag ? best_end : '0;
    ovf_res.best_score  = best_flag ? best_total : '0;
    ovf_res.last_out    = cur.last_dot;
  end

  always_ff @(posedge clk) begin
    if (state == ST_IDLE && in_valid) cur <= in_data;
    // Cost stage.
    c_ok    <= (e_row < cur.dot_row) && (e_col < cur.dot_col) &&
               !e_chain[SCORE_W-1] && (e_chain != '0);
    c_chain <= e_chain;
    c_row   <= e_row;
    c_col   <= e_col;
    c_id    <= e_id;
    c_rgap  <= (drow > POS_W'(1));
    c_cgap  <= (dcol > POS_W'(1));
    c_rprod <= PROD_W'(row_ext) * PROD_W'($signed({1'b0, drow}));
    c_cprod <= PROD_W'(col_ext) * PROD_W'($signed({1'b0, dcol}));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      kept_count <= '0;
      dot_counter <= '0;
      scan_cnt <= '0;
      best_end <= '0;
      best_total <= '0;
      best_flag <= 1'b0;
      v_rd <= 1'b0;
      v_cost <= 1'b0;
      b_has <= 1'b0;
      b_score <= '0;
    end else begin
      state <= state_next;
      v_rd   <= (state == ST_SCAN) && !scan_done && !ovf_now;
      v_cost <= v_rd;
      if (state == ST_IDLE) begin
        scan_cnt <= '0;
        b_has <= 1'b0;
        b_score <= '0;
      end
      if (state == ST_SCAN && !scan_done) scan_cnt <= scan_cnt + CNT_W'(1);
      if (v_cost && c_ok && take) begin
        b_has <= 1'b1;
        b_score <= cand;
        b_row <= c_row;
        b_col <= c_col;
        b_id <= c_id;
      end
      if (state == ST_SCAN && ovf_now) res <= ovf_res;
      if (state == ST_FINISH) begin
        res <= fin_res;
        dot_counter <= dot_counter + CNT_W'(1);
        if (!chain_f[SCORE_W-1]) kept_count <= kept_count + CNT_W'(1);
        if (best_up) begin
          best_total <= chain_f[SCORE_W-2:0];
          best_end <= me;
          best_flag <= 1'b1;
        end
      end
      if (state == ST_OUT && out_ready && cur.last_dot) begin
        kept_count <= '0;
        dot_counter <= '0;
        best_end <= '0;
        best_total <= '0;
        best_flag <= 1'b0;
      end
    end
  end

`ifndef NO_ASSERTIONS
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |-> !out_valid) else $error("dot accepted while result pending");
  a_wr_bound: assert property (@(posedge clk) disable iff (rst)
    wr_en |-> (kept_count < CNT_W'(MAX_DOTS))) else $error("store write beyond depth");
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_data)))
    else $error("result changed while stalled");
`endif

endmodule
